FILE: rtl/htlt_pkg.sv
package htlt_pkg;

   // Fixed field widths of the request and configuration words.
   localparam int OPCODE_W = 2;
   localparam int NODE_W   = 6;
   localparam int COUNT_W  = 7;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_USER_BITS = 16;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Configuration port geometry: one register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_NODE_COUNT = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_LOCK    = 2'd1,
      OP_UNLOCK  = 2'd2,
      OP_UPGRADE = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic ok_set;
      logic ok_value;
      logic write_parent;
      logic take;
      logic release_node;
      logic clear_desc;
      logic walk_start;
      logic walk_desc;
      logic walk_step;
      logic scan_clear;
      logic scan_inc;
      logic mark_desc;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   held;
      logic   owner_match;
      logic   walk_done;
      logic   walk_hit;
      logic   scan_end;
      logic   scan_held;
      logic   desc_any;
   } status_type;

endpackage

FILE: rtl/htlt_req_if.sv
interface htlt_req_if #(
   parameter int USER_BITS = htlt_pkg::DEF_USER_BITS
);
   logic                             valid;
   logic                             ready;
   logic [htlt_pkg::OPCODE_W-1:0]    opcode;
   logic [htlt_pkg::NODE_W-1:0]      node;
   logic [USER_BITS-1:0]             user_id;
   logic [htlt_pkg::NODE_W-1:0]      parent_index;

   modport source (output valid, output opcode, output node, output user_id,
                   output parent_index, input ready);
   modport sink   (input valid, input opcode, input node, input user_id,
                   input parent_index, output ready);
endinterface

FILE: rtl/htlt_rsp_if.sv
interface htlt_rsp_if;
   logic valid;
   logic ready;
   logic success;

   modport source (output valid, output success, input ready);
   modport sink   (input valid, input success, output ready);
endinterface

FILE: rtl/hierarchical_tree_lock_table_top.sv
// Lock table over a tree of nodes whose root is node 0.
// Request words arrive on req_if (opcode, node, user_id, parent_index) and one
// response word per request leaves on rsp_if (success). Both use valid/ready;
// a word moves at a clock edge where both are high. The APB port holds the
// node_count register at byte address 0; pready is always high.
// Load and lock requests go from decode to the finish state; unlock checks
// the owner in a state of its own. An upgrade walks parent links, one link
// per cycle through the single read port of the parent memory: one walk up
// from the node, then, if no locked ancestor is found, a scan of all n in-use
// nodes that walks up from every locked one (n is node_count capped at
// MAX_NODES). One request is in flight at a time.
// A finished response sits in an output register, so the next request is
// accepted while it waits; when the receiver stalls, the following request
// holds in its final cycle until the output register frees up.
// Reset clears all locks and sets node_count to 64. The parent and owner
// memories are not cleared and must be loaded before they are walked.
module hierarchical_tree_lock_table_top #(
   parameter int MAX_NODES = htlt_pkg::DEF_MAX_NODES,
   parameter int USER_BITS = htlt_pkg::DEF_USER_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   htlt_req_if.sink                           req_if,
   htlt_rsp_if.source                         rsp_if,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [htlt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [htlt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [htlt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   // The controller sequences each request; the datapath owns the memories,
   // the lock vector and the parent-link walker.
   htlt_pkg::cmd_type    cmd;
   htlt_pkg::status_type st;

   assign pready = 1'b1;

   htlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .st        (st),
      .cmd       (cmd)
   );

   htlt_dp #(
      .MAX_NODES (MAX_NODES),
      .USER_BITS (USER_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_if.opcode),
      .req_node         (req_if.node),
      .req_user_id      (req_if.user_id),
      .req_parent_index (req_if.parent_index),
      .rsp_success      (rsp_if.success),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .cmd              (cmd),
      .st               (st)
   );

endmodule

FILE: rtl/htlt_ctrl.sv
module htlt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  htlt_pkg::status_type st,
   output htlt_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_DECODE     = 8'b0000_0010,
      S_UNLOCK_CHK = 8'b0000_0100,
      S_ANC_WALK   = 8'b0000_1000,
      S_DESC_SCAN  = 8'b0001_0000,
      S_DESC_WALK  = 8'b0010_0000,
      S_COMMIT     = 8'b0100_0000,
      S_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (st.op)
               htlt_pkg::OP_LOAD: begin
                  cmd.write_parent = 1'b1;
                  cmd.ok_set       = 1'b1;
                  cmd.ok_value     = 1'b1;
                  state_in         = S_FINISH;
               end
               htlt_pkg::OP_LOCK: begin
                  cmd.take     = st.in_range & ~st.held;
                  cmd.ok_set   = 1'b1;
                  cmd.ok_value = st.in_range & ~st.held;
                  state_in     = S_FINISH;
               end
               htlt_pkg::OP_UNLOCK: begin
                  state_in = S_UNLOCK_CHK;
               end
               htlt_pkg::OP_UPGRADE: begin
                  if (st.in_range && !st.held) begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_ANC_WALK;
                  end else begin
                     cmd.ok_set = 1'b1;
                     state_in   = S_FINISH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_UNLOCK_CHK: begin
            cmd.release_node = st.in_range & st.held & st.owner_match;
            cmd.ok_set       = 1'b1;
            cmd.ok_value     = st.in_range & st.held & st.owner_match;
            state_in         = S_FINISH;
         end
         S_ANC_WALK: begin
            cmd.walk_step = 1'b1;
            if (st.walk_done) begin
               if (st.walk_hit) begin
                  cmd.ok_set = 1'b1;
                  state_in   = S_FINISH;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_DESC_SCAN;
               end
            end
         end
         S_DESC_SCAN: begin
            priority if (st.scan_end) begin
               if (st.desc_any) begin
                  state_in = S_COMMIT;
               end else begin
                  cmd.ok_set = 1'b1;
                  state_in   = S_FINISH;
               end
            end else if (st.scan_held) begin
               cmd.walk_start = 1'b1;
               cmd.walk_desc  = 1'b1;
               state_in       = S_DESC_WALK;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_DESC_WALK: begin
            cmd.walk_step = 1'b1;
            if (st.walk_done) begin
               cmd.mark_desc = 1'b1;
               cmd.scan_inc  = 1'b1;
               state_in      = S_DESC_SCAN;
            end
         end
         S_COMMIT: begin
            cmd.clear_desc = 1'b1;
            cmd.take       = 1'b1;
            cmd.ok_set     = 1'b1;
            cmd.ok_value   = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/htlt_dp.sv
module htlt_dp #(
   parameter int MAX_NODES = htlt_pkg::DEF_MAX_NODES,
   parameter int USER_BITS = htlt_pkg::DEF_USER_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [htlt_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [htlt_pkg::NODE_W-1:0]        req_node,
   input  logic [USER_BITS-1:0]               req_user_id,
   input  logic [htlt_pkg::NODE_W-1:0]        req_parent_index,
   output logic                               rsp_success,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [htlt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [htlt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [htlt_pkg::CSR_DATA_W-1:0]    prdata,
   input  htlt_pkg::cmd_type                  cmd,
   output htlt_pkg::status_type               st
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CAP   = (MAX_NODES < 127) ? MAX_NODES : 127;
   localparam int CW    = htlt_pkg::COUNT_W;
   localparam int NW    = htlt_pkg::NODE_W;

   // Node count register.
   logic [CW-1:0]                    cnt_ff;
   logic [htlt_pkg::CSR_IDX_W-1:0]   csr_index;
   logic                             csr_write;

   // Captured request.
   logic [htlt_pkg::OPCODE_W-1:0]    op_ff;
   logic [NW-1:0]                    nd_ff;
   logic [USER_BITS-1:0]             user_ff;
   logic [NW-1:0]                    par_ff;

   // Lock state and upgrade bookkeeping.
   logic [MAX_NODES-1:0]             lock_held_ff, lock_held_in;
   logic [MAX_NODES-1:0]             desc_ff, desc_in;
   logic                             any_ff, any_in;

   // Memories.
   logic [NW-1:0]                    parent_mem [MAX_NODES];
   logic [USER_BITS-1:0]             owner_mem  [MAX_NODES];
   logic [NW-1:0]                    parent_rd_ff;
   logic [USER_BITS-1:0]             owner_rd_ff;

   // Parent-link walker and scan.
   logic [CW-1:0]                    cur_ff, cur_in;
   logic [CW-1:0]                    step_ff, step_in;
   logic                             mode_ff;
   logic [CW-1:0]                    scan_ff, scan_in;
   logic                             ok_ff;
   logic                             rsp_success_ff;

   logic [CW-1:0]                    n_eff;
   logic [IDX_W-1:0]                 nd_idx, p_idx, scan_idx, seed_idx, parent_addr;
   logic [CW-1:0]                    seed;
   logic [CW-1:0]                    step_next;
   logic                             nd_fits, cur_zero, p_out, p_hit;

   assign csr_index = paddr[htlt_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel & penable & pwrite & (csr_index == htlt_pkg::CSR_IDX_NODE_COUNT);
   assign prdata    = (csr_index == htlt_pkg::CSR_IDX_NODE_COUNT) ?
                      {{(htlt_pkg::CSR_DATA_W-CW){1'b0}}, cnt_ff} : '0;

   assign n_eff    = (cnt_ff < CW'(CAP)) ? cnt_ff : CW'(CAP);
   assign nd_fits  = ({{(32-NW){1'b0}}, nd_ff} < 32'(MAX_NODES));
   assign nd_idx   = IDX_W'(nd_ff);
   assign p_idx    = IDX_W'(parent_rd_ff);
   assign scan_idx = IDX_W'(scan_ff);
   assign seed     = cmd.walk_desc ? scan_ff : {1'b0, nd_ff};
   assign seed_idx = IDX_W'(seed);

   // A link is followed only from a nonzero node; the walk ends on a link out
   // of range, on a hit, or once the step budget of n_eff is spent.
   assign cur_zero  = (cur_ff == '0);
   assign p_out     = ({1'b0, parent_rd_ff} >= n_eff);
   assign p_hit     = mode_ff ? (parent_rd_ff == nd_ff) : lock_held_ff[p_idx];
   assign step_next = step_ff + 1'b1;

   assign parent_addr = cmd.walk_step ? p_idx : seed_idx;

   assign st.op          = htlt_pkg::op_type'(op_ff);
   assign st.in_range    = ({1'b0, nd_ff} < n_eff);
   assign st.held        = lock_held_ff[nd_idx];
   assign st.owner_match = (owner_rd_ff == user_ff);
   assign st.walk_done   = cur_zero | p_out | p_hit | (step_next == n_eff);
   assign st.walk_hit    = ~cur_zero & ~p_out & p_hit;
   assign st.scan_end    = (scan_ff == n_eff);
   assign st.scan_held   = lock_held_ff[scan_idx];
   assign st.desc_any    = any_ff;

   assign rsp_success = rsp_success_ff;

   always_comb begin
      lock_held_in = lock_held_ff;
      if (cmd.clear_desc) begin
         lock_held_in = lock_held_in & ~desc_ff;
      end
      if (cmd.take) begin
         lock_held_in[nd_idx] = 1'b1;
      end
      if (cmd.release_node) begin
         lock_held_in[nd_idx] = 1'b0;
      end
   end

   always_comb begin
      desc_in = desc_ff;
      any_in  = any_ff;
      if (cmd.scan_clear) begin
         desc_in = '0;
         any_in  = 1'b0;
      end else if (cmd.mark_desc && st.walk_hit) begin
         desc_in[scan_idx] = 1'b1;
         any_in            = 1'b1;
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      step_in = step_ff;
      if (cmd.walk_start) begin
         cur_in  = seed;
         step_in = '0;
      end else if (cmd.walk_step) begin
         cur_in  = {1'b0, parent_rd_ff};
         step_in = step_next;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= htlt_pkg::NODE_COUNT_RESET;
         lock_held_ff <= '0;
      end else begin
         if (csr_write) begin
            cnt_ff <= pwdata[CW-1:0];
         end
         lock_held_ff <= lock_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         nd_ff   <= req_node;
         user_ff <= req_user_id;
         par_ff  <= req_parent_index;
      end
      if (cmd.walk_start) begin
         mode_ff <= cmd.walk_desc;
      end
      if (cmd.ok_set) begin
         ok_ff <= cmd.ok_value;
      end
      if (cmd.rsp_load) begin
         rsp_success_ff <= ok_ff;
      end
      desc_ff <= desc_in;
      any_ff  <= any_in;
      cur_ff  <= cur_in;
      step_ff <= step_in;
      scan_ff <= scan_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_parent && nd_fits) begin
         parent_mem[nd_idx] <= par_ff;
      end
      parent_rd_ff <= parent_mem[parent_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         owner_mem[nd_idx] <= user_ff;
      end
      owner_rd_ff <= owner_mem[nd_idx];
   end

endmodule
